/* rtl/calendar_add_days_hours_assert.svh */
// ---------------------------------------------------------------------------
// calendar_add_days_hours_assert.svh
// Assertion macros used by the calendar block's port checker.
// ---------------------------------------------------------------------------
`ifndef CALENDAR_ADD_DAYS_HOURS_ASSERT_SVH
`define CALENDAR_ADD_DAYS_HOURS_ASSERT_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is held.
`define CADH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Concurrent assertion that is also checked while reset is held.
`define CADH_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/cadh_pkg.sv */
// ---------------------------------------------------------------------------
// cadh_pkg
// Payload types, field widths and calendar constants of the date adder.
// ---------------------------------------------------------------------------
package cadh_pkg;

    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int AMT_W   = 16;

    // Hour sum and its split into whole days.
    localparam int SUM_W       = 17;
    localparam int DIV3_MUL_W  = 16;
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 16'd43691;
    localparam int DIV3_SHIFT  = 17;
    localparam int PROD_W      = SUM_W - 3 + DIV3_MUL_W;
    localparam int Q_W         = PROD_W - DIV3_SHIFT;

    localparam int LEN_W = 9;
    localparam logic [LEN_W-1:0] DAYS_YEAR = 9'd365;
    localparam logic [LEN_W-1:0] DAYS_LEAP = 9'd366;

    localparam int LEAP_CENTURY = 100;
    localparam int LEAP_QUAD    = 400;
    localparam int C100_W       = 7;
    localparam int C400_W       = 9;

    localparam logic [YEAR_W-1:0]  TWO_DIGIT_LIMIT = 16'd100;
    localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
    localparam logic [MONTH_W-1:0] MONTHS          = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_LIMIT     = 4'd13;

    localparam logic REQ_HOURS = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [YEAR_W-1:0]  year_in;
        logic [MONTH_W-1:0] month_in;
        logic [DAY_W-1:0]   day_in;
        logic [HOUR_W-1:0]  hour_in;
        logic [AMT_W-1:0]   amount;
    } t_in;

    typedef struct packed {
        logic [YEAR_W-1:0]  year_out;
        logic [MONTH_W-1:0] month_out;
        logic [DAY_W-1:0]   day_out;
        logic [HOUR_W-1:0]  hour_out;
    } t_out;

    // Length of a month (1 to 12) in days.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mo,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        if (mo == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (mo inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

/* rtl/calendar_add_days_hours.sv */
// ---------------------------------------------------------------------------
// calendar_add_days_hours
// Adds a number of days or hours to a Gregorian date and hour of day.
// ---------------------------------------------------------------------------
// Usage: one request enters on the input channel (i_in_valid, o_in_stall,
// i_in_data) and one result leaves on the output channel (o_out_valid,
// i_out_stall, o_out_data). A transfer happens at a clock edge where valid
// is high and stall is low. The block works on one request at a time and
// stalls its input from the transfer until the result has been taken.
// Operation: the date is turned into a day count from BASE_YEAR-01-01, the
// amount is added and the count is split back into a date, all through one
// shared add/subtract/compare unit, one step per cycle. Hours mode first
// splits the hour sum into whole days and an hour of day. The year is then
// folded by repeated subtraction of BASE_YEAR, the days of each year from
// BASE_YEAR to the input year and of each earlier month are added, and
// whole years and months are taken off the count again to form the result.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_out_valid. A stalled result holds o_out_valid and o_out_data unchanged
// until the receiver takes it; the next request is accepted afterwards.
// ---------------------------------------------------------------------------
module calendar_add_days_hours
    import cadh_pkg::*;
#(
    parameter int BASE_YEAR = 2000
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    // The day count must hold every input year's offset plus the amount.
    localparam int CNT_MAX = BASE_YEAR * int'(DAYS_LEAP) + (2 ** AMT_W)
                             + 2 * int'(DAYS_LEAP);
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int ALU_W   = (CNT_W > YEAR_W) ? CNT_W : YEAR_W;

    localparam logic [YEAR_W-1:0] BASE_Y    = YEAR_W'(BASE_YEAR);
    localparam logic [C100_W-1:0] BASE_C100 = C100_W'(BASE_YEAR % LEAP_CENTURY);
    localparam logic [C400_W-1:0] BASE_C400 = C400_W'(BASE_YEAR % LEAP_QUAD);
    localparam logic [C100_W-1:0] C100_LAST = C100_W'(LEAP_CENTURY - 1);
    localparam logic [C400_W-1:0] C400_LAST = C400_W'(LEAP_QUAD - 1);

    // Sequencer states, one-hot.
    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,  // waiting for a request
        S_DIV  = 11'b000_0000_0010,  // hour sum divided by 24
        S_HREM = 11'b000_0000_0100,  // hour remainder, whole days
        S_FOLD = 11'b000_0000_1000,  // fold the year into the valid range
        S_DAY  = 11'b000_0001_0000,  // add the day of month
        S_YACC = 11'b000_0010_0000,  // count whole years from the base
        S_MACC = 11'b000_0100_0000,  // count whole months of the year
        S_CHK  = 11'b000_1000_0000,  // zero count keeps the date
        S_YSUB = 11'b001_0000_0000,  // take whole years off the count
        S_MSUB = 11'b010_0000_0000,  // take whole months off the count
        S_OUT  = 11'b100_0000_0000   // result offered downstream
    } t_state;

    t_state r_state, n_state;

    logic                r_type,  n_type;
    logic [YEAR_W-1:0]   r_yin,   n_yin;
    logic [YEAR_W-1:0]   r_off,   n_off;
    logic [YEAR_W-1:0]   r_yr,    n_yr;
    logic [MONTH_W-1:0]  r_m,     n_m;
    logic [MONTH_W-1:0]  r_mo,    n_mo;
    logic [DAY_W-1:0]    r_d,     n_d;
    logic [HOUR_W-1:0]   r_h,     n_h;
    logic [SUM_W-1:0]    r_sum,   n_sum;
    logic [Q_W-1:0]      r_q,     n_q;
    logic [ALU_W-1:0]    r_acc,   n_acc;
    logic [C100_W-1:0]   r_c100,  n_c100;
    logic [C400_W-1:0]   r_c400,  n_c400;
    logic                r_first, n_first;
    logic                r_valid, n_valid;
    logic                r_keep,  n_keep;

    // Leap year tracking for the year counter, kept as running remainders.
    logic                leap;
    logic [LEN_W-1:0]    year_len;
    logic [DAY_W-1:0]    mon_len;
    logic [MONTH_W-1:0]  mlim;
    logic [YEAR_W-1:0]   yr_inc;
    logic [C100_W-1:0]   c100_inc;
    logic [C400_W-1:0]   c400_inc;

    assign leap     = ((r_yr[1:0] == 2'b00) && (r_c100 != '0)) || (r_c400 == '0);
    assign year_len = leap ? DAYS_LEAP : DAYS_YEAR;
    assign mon_len  = month_days(r_mo, leap);
    assign mlim     = (r_m > MONTH_LIMIT) ? MONTH_LIMIT : r_m;
    assign yr_inc   = r_yr + YEAR_W'(1);
    assign c100_inc = (r_c100 == C100_LAST) ? '0 : r_c100 + C100_W'(1);
    assign c400_inc = (r_c400 == C400_LAST) ? '0 : r_c400 + C400_W'(1);

    // Hour sum split into days: (sum / 8) / 3 by a reciprocal multiply.
    logic [PROD_W-1:0]   prod;
    logic [SUM_W-1:0]    q24;
    logic [SUM_W-1:0]    hrem;

    assign prod = PROD_W'(r_sum[SUM_W-1:3]) * PROD_W'(DIV3_MUL);
    assign q24  = (SUM_W'(r_q) << 4) + (SUM_W'(r_q) << 3);
    assign hrem = r_sum - q24;

    // Shared add/subtract unit. With subtraction the carry out is a >= b.
    logic                alu_sub;
    logic [ALU_W-1:0]    alu_a;
    logic [ALU_W-1:0]    alu_b;
    logic [ALU_W:0]      alu_res;
    logic                alu_ge;
    logic [ALU_W-1:0]    alu_val;
    logic [DAY_W-1:0]    d_less1;

    assign d_less1 = r_d - DAY_W'(1);

    always_comb begin
        alu_a   = r_acc;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_FOLD: begin
                alu_a   = ALU_W'(r_off);
                alu_b   = ALU_W'(BASE_Y);
                alu_sub = 1'b1;
            end
            S_DAY: begin
                alu_b = r_valid ? ALU_W'(d_less1) : '0;
            end
            S_YACC: begin
                alu_b = ALU_W'(year_len);
            end
            S_MACC: begin
                alu_b = ALU_W'(mon_len);
            end
            S_YSUB: begin
                alu_b   = ALU_W'(year_len);
                alu_sub = 1'b1;
            end
            S_MSUB: begin
                alu_b   = ALU_W'(mon_len);
                alu_sub = 1'b1;
            end
            default: begin
                alu_b = '0;
            end
        endcase
    end

    assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (ALU_W + 1)'(alu_sub);
    assign alu_ge  = alu_res[ALU_W];
    assign alu_val = alu_res[ALU_W-1:0];

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_type  = r_type;
        n_yin   = r_yin;
        n_off   = r_off;
        n_yr    = r_yr;
        n_m     = r_m;
        n_mo    = r_mo;
        n_d     = r_d;
        n_h     = r_h;
        n_sum   = r_sum;
        n_q     = r_q;
        n_acc   = r_acc;
        n_c100  = r_c100;
        n_c400  = r_c400;
        n_first = r_first;
        n_valid = r_valid;
        n_keep  = r_keep;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_type  = i_in_data.req_type;
                    n_yin   = i_in_data.year_in;
                    n_off   = i_in_data.year_in;
                    n_m     = i_in_data.month_in;
                    n_d     = i_in_data.day_in;
                    n_h     = i_in_data.hour_in;
                    n_sum   = SUM_W'(i_in_data.hour_in) + SUM_W'(i_in_data.amount);
                    n_acc   = ALU_W'(i_in_data.amount);
                    n_yr    = BASE_Y;
                    n_c100  = BASE_C100;
                    n_c400  = BASE_C400;
                    n_first = 1'b1;
                    n_keep  = 1'b0;
                    n_state = (i_in_data.req_type == REQ_HOURS) ? S_DIV : S_FOLD;
                end
            end
            S_DIV: begin
                n_q     = prod[DIV3_SHIFT +: Q_W];
                n_state = S_HREM;
            end
            S_HREM: begin
                n_h   = hrem[HOUR_W-1:0];
                n_acc = ALU_W'(r_q);
                // Less than a whole day: the date passes through untouched.
                if (r_q == '0) begin
                    n_keep  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (alu_ge) begin
                    n_off   = alu_val[YEAR_W-1:0];
                    n_first = 1'b0;
                end else begin
                    // A year from 100 up to just below the base year is invalid, as are
                    // a zero month and a zero day: the count starts at zero.
                    n_valid = (r_m != '0) && (r_d != '0)
                              && !(r_first && (r_off >= TWO_DIGIT_LIMIT));
                    if (!n_valid) begin
                        n_off = '0;
                    end
                    n_state = S_DAY;
                end
            end
            S_DAY: begin
                n_acc   = alu_val;
                n_state = S_YACC;
            end
            S_YACC: begin
                if (r_off == '0) begin
                    n_mo    = MONTH_W'(1);
                    n_state = S_MACC;
                end else begin
                    n_acc  = alu_val;
                    n_off  = r_off - YEAR_W'(1);
                    n_yr   = yr_inc;
                    n_c100 = c100_inc;
                    n_c400 = c400_inc;
                end
            end
            S_MACC: begin
                if (!r_valid || (r_mo >= mlim)) begin
                    n_state = S_CHK;
                end else begin
                    n_acc = alu_val;
                    n_mo  = r_mo + MONTH_W'(1);
                end
            end
            S_CHK: begin
                if (r_acc == '0) begin
                    n_keep  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_yr    = BASE_Y;
                    n_c100  = BASE_C100;
                    n_c400  = BASE_C400;
                    n_state = S_YSUB;
                end
            end
            S_YSUB: begin
                if (!alu_ge) begin
                    n_mo    = MONTH_W'(1);
                    n_state = S_MSUB;
                end else begin
                    n_acc  = alu_val;
                    n_yr   = yr_inc;
                    n_c100 = c100_inc;
                    n_c400 = c400_inc;
                end
            end
            S_MSUB: begin
                if ((r_mo == MONTHS) || !alu_ge) begin
                    n_state = S_OUT;
                end else begin
                    n_acc = alu_val;
                    n_mo  = r_mo + MONTH_W'(1);
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type  <= n_type;
        r_yin   <= n_yin;
        r_off   <= n_off;
        r_yr    <= n_yr;
        r_m     <= n_m;
        r_mo    <= n_mo;
        r_d     <= n_d;
        r_h     <= n_h;
        r_sum   <= n_sum;
        r_q     <= n_q;
        r_acc   <= n_acc;
        r_c100  <= n_c100;
        r_c400  <= n_c400;
        r_first <= n_first;
        r_valid <= n_valid;
        r_keep  <= n_keep;
    end

    // The input stays stalled for the whole request; the result is held in
    // the working registers while it waits in S_OUT. In days mode r_type is
    // clear and r_h still holds the input hour.
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        if (r_keep) begin
            o_out_data.year_out  = r_yin;
            o_out_data.month_out = r_m;
            o_out_data.day_out   = r_d;
        end else begin
            o_out_data.year_out  = r_yr;
            o_out_data.month_out = r_mo;
            o_out_data.day_out   = r_acc[DAY_W-1:0] + DAY_W'(1);
        end
        o_out_data.hour_out = (r_type == REQ_HOURS) ? r_h : r_h;
    end

endmodule

/* rtl/cadh_checker.sv */
// ---------------------------------------------------------------------------
// cadh_port_checker
// Port-level checks of the calendar block's handshake and sequencing.
// ---------------------------------------------------------------------------
`include "calendar_add_days_hours_assert.svh"

module cadh_port_checker
    import cadh_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    logic in_xfer;
    logic out_held;
    logic working;
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_held = o_out_valid && i_out_stall;
    assign working  = o_in_stall && !o_out_valid;

    `CADH_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `CADH_ASSERT(a_hold_stalled, out_held |=> o_out_valid && $stable(o_out_data), "result moved")
    `CADH_ASSERT(a_busy_while_result, o_out_valid |-> o_in_stall, "input open during result")
    `CADH_ASSERT(a_accept_then_busy, in_xfer |=> working, "no busy period after a transfer")

endmodule

bind calendar_add_days_hours cadh_port_checker u_cadh_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
